// File: rtl/nprc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nprc_pkg: shared types and constants of the neighbour predictive coder
// Payload structures of the three channels, register indexes, prediction
// modes and the position flags passed from the scan tracker.
// ----------------------------------------------------------------------------
package nprc_pkg;

  localparam int PIX_W                  = 8;
  localparam int RES_W                  = 9;
  localparam int MODE_W                 = 2;
  localparam int LINE_WIDTH_W           = 11;
  localparam int CFG_INDEX_W            = 1;
  localparam int DEF_MAX_LINE_WIDTH     = 1024;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_WEST  = 2'd0,
    MODE_NORTH = 2'd1,
    MODE_ADAPT = 2'd2,
    MODE_GRAD  = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE       = 1'b0,
    REG_LINE_WIDTH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic signed [RES_W-1:0] residual;
    logic [PIX_W-1:0]        coded;
    logic                    direction;
    logic                    direction_valid;
    logic                    row_end;
  } res_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0]  index;
    logic [LINE_WIDTH_W-1:0] wdata;
  } cfg_t;

  // Neighbour availability and row position of one pixel
  typedef struct packed {
    logic has_w;
    logic has_n;
    logic last;
  } pos_t;

endpackage
`default_nettype wire

// File: rtl/nprc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nprc channel interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface nprc_pix_if;
  import nprc_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nprc_res_if;
  import nprc_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nprc_cfg_if;
  import nprc_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/neighbor_predictive_residual_coder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_predictive_residual_coder: DPCM coder for 8-bit raster images
// Predicts each pixel from its west or north neighbour and emits the
// residual, a normalised code, the adaptive choice and an end-of-row flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan   pixel and frame_start, one transaction per pixel in raster
//             order; frame_start restarts row and column at that pixel.
//   out_chan  exactly one result transaction per pixel, in input order.
//   cfg_chan  register writes (index 0 mode, index 1 line_width); always
//             ready, to be written only while the coder is idle.
// A pixel is registered in the middle stage, then in the output register;
// they carry up to two pixels in flight. One pixel is taken every clock
// unless both are full; the line buffer does one read and one write of
// the same entry per pixel.
// When the receiver stalls, the output register holds its result, the
// middle stage fills, and in_chan.ready drops only once both are full.
// Reset (synchronous, rst_n low) sets mode 0, line_width 1024, clears the
// west and northwest samples and the column, and marks the first row. The
// line buffer is not cleared: the first row of a frame ignores its reads.
// ----------------------------------------------------------------------------
module neighbor_predictive_residual_coder #(
  parameter int MAX_LINE_WIDTH = nprc_pkg::DEF_MAX_LINE_WIDTH
) (
  input wire logic     clk,
  input wire logic     rst_n,
  nprc_pix_if.sink     in_chan,
  nprc_res_if.source   out_chan,
  nprc_cfg_if.sink     cfg_chan
);
  import nprc_pkg::*;

  localparam int AW = $clog2(MAX_LINE_WIDTH);

  // Configuration registers
  mode_t                   mode_r;
  logic [LINE_WIDTH_W-1:0] line_width_r;

  // Accept side
  logic          in_acc;
  logic [AW-1:0] col;
  pos_t          pos;

  // Middle stage: pixel waiting for its north sample
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r;
  pos_t             s1_pos_r;
  logic [PIX_W-1:0] north;
  logic             s1_adv;

  // Neighbour history, advanced as each pixel leaves the middle stage
  logic [PIX_W-1:0] west_r, northwest_r;

  // Output register
  logic out_valid_r;
  res_t out_data_r;
  res_t result;

  // Register writes: always ready, decode index
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_WEST;
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_idx_t'(cfg_chan.data.index))
        REG_MODE:       mode_r       <= mode_t'(cfg_chan.data.wdata[MODE_W-1:0]);
        REG_LINE_WIDTH: line_width_r <= cfg_chan.data.wdata;
        default:        mode_r       <= mode_r;
      endcase
    end
  end

  // Advance the middle stage when the output register is free or draining
  assign s1_adv        = s1_valid_r & (~out_valid_r | out_chan.ready);
  assign in_chan.ready = ~s1_valid_r | s1_adv;
  assign in_acc        = in_chan.valid & in_chan.ready;

  nprc_scan #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .AW             (AW)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (in_acc),
    .frame_start (in_chan.data.frame_start),
    .line_width  (line_width_r),
    .col         (col),
    .pos         (pos)
  );

  // Read the north sample and overwrite it with this pixel in one access
  nprc_line_buf #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk       (clk),
    .en        (in_acc),
    .addr      (col),
    .wr_data   (in_chan.data.pixel),
    .rd_data_r (north)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Hold the pixel and its flags alongside the registered north sample
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_chan.data.pixel;
      s1_pos_r   <= pos;
    end
  end

  nprc_predict u_predict (
    .mode      (mode_r),
    .pixel     (s1_pixel_r),
    .west      (west_r),
    .northwest (northwest_r),
    .north     (north),
    .pos       (s1_pos_r),
    .result    (result)
  );

  // The pixel just coded becomes west, its north becomes northwest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      west_r      <= '0;
      northwest_r <= '0;
    end else if (s1_adv) begin
      west_r      <= s1_pixel_r;
      northwest_r <= north;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/nprc_line_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nprc_line_buf: previous-row line buffer
// Single-port memory, read-first: one read and one write of the same entry
// per accepted pixel, read data registered.
// ----------------------------------------------------------------------------
module nprc_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [AW-1:0]              addr,
  input  wire logic [nprc_pkg::PIX_W-1:0] wr_data,
  output logic      [nprc_pkg::PIX_W-1:0] rd_data_r
);
  import nprc_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/nprc_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nprc_scan: raster position tracker
// Holds column and first-row state, clamps the column to the effective
// row width and flags neighbour availability and the end of each row.
// ----------------------------------------------------------------------------
module nprc_scan #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int AW             = $clog2(MAX_LINE_WIDTH)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              frame_start,
  input  wire logic [nprc_pkg::LINE_WIDTH_W-1:0] line_width,
  output logic      [AW-1:0]                     col,
  output nprc_pkg::pos_t                         pos
);
  import nprc_pkg::*;

  localparam int WW   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CMPW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;

  logic [AW-1:0]   cc_r, cc_nxt, cc_start;
  logic            first_r, first_nxt, first;
  logic [CMPW-1:0] lw_ext;
  logic [WW-1:0]   width, col_p1;

  always_comb begin
    lw_ext = CMPW'(line_width);
    // Zero acts as one pixel, oversize clamps to the buffer depth
    if (line_width == '0) begin
      width = WW'(1);
    end else if (lw_ext > CMPW'(MAX_LINE_WIDTH)) begin
      width = WW'(MAX_LINE_WIDTH);
    end else begin
      width = WW'(lw_ext);
    end

    cc_start = frame_start ? '0 : cc_r;
    first    = frame_start | first_r;

    // Column past a shrunk row width ends the row at its last column
    if (WW'(cc_start) >= width) begin
      col = AW'(width - WW'(1));
    end else begin
      col = cc_start;
    end

    col_p1    = WW'(col) + WW'(1);
    pos.last  = (col_p1 >= width);
    pos.has_w = (col != '0);
    pos.has_n = ~first;

    if (pos.last) begin
      cc_nxt    = '0;
      first_nxt = 1'b0;
    end else begin
      cc_nxt    = AW'(col_p1);
      first_nxt = first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= '0;
      first_r <= 1'b1;
    end else if (adv) begin
      cc_r    <= cc_nxt;
      first_r <= first_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/nprc_predict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nprc_predict: predictor and residual coder
// Selects the prediction for the configured mode, forms the signed
// residual, the normalised code and the adaptive direction bit.
// ----------------------------------------------------------------------------
module nprc_predict (
  input  wire nprc_pkg::mode_t             mode,
  input  wire logic [nprc_pkg::PIX_W-1:0]  pixel,
  input  wire logic [nprc_pkg::PIX_W-1:0]  west,
  input  wire logic [nprc_pkg::PIX_W-1:0]  northwest,
  input  wire logic [nprc_pkg::PIX_W-1:0]  north,
  input  wire nprc_pkg::pos_t              pos,
  output nprc_pkg::res_t                   result
);
  import nprc_pkg::*;

  logic [PIX_W-1:0] pred, d_xw, d_xn, d_nnw, d_wnw;
  logic [PIX_W:0]   code_sum;
  logic             both;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    d_xw  = abs_diff(pixel, west);
    d_xn  = abs_diff(pixel, north);
    d_nnw = abs_diff(north, northwest);
    d_wnw = abs_diff(west, northwest);
    both  = pos.has_w & pos.has_n;

    pred                   = '0;
    result.direction       = 1'b0;
    result.direction_valid = 1'b0;

    case (mode)
      MODE_WEST: begin
        if (pos.has_w) pred = west;
      end
      MODE_NORTH: begin
        if (pos.has_n) pred = north;
      end
      MODE_ADAPT: begin
        if (both) begin
          result.direction_valid = 1'b1;
          if (d_xw < d_xn) begin
            pred = west;
          end else begin
            pred             = north;
            result.direction = 1'b1;
          end
        end
      end
      MODE_GRAD: begin
        if (both) pred = (d_nnw < d_wnw) ? west : north;
      end
      default: begin
        pred = '0;
      end
    endcase

    result.residual = $signed({1'b0, pixel}) - $signed({1'b0, pred});
    // residual + 255 = pixel + (255 - pred), never negative
    code_sum        = {1'b0, pixel} + {1'b0, ~pred};
    result.coded    = code_sum[PIX_W:1];
    result.row_end  = pos.last;
  end

endmodule
`default_nettype wire
